>>> design/lav_pkg.sv
// ============================================================================
// lav_pkg: shared types, constants and arithmetic steps of the look-at block
// Holds the payload structs, the fixed-point widths, the pipelined square
// root and division steps, and the rounding helpers.
// ============================================================================
`default_nettype none

package lav_pkg;

    // Q16.16 field width and the constant one
    localparam int D_W = 32;
    localparam logic signed [D_W-1:0] Q_ONE = 32'sd65536;

    // Row codes
    localparam logic [1:0] ROW0 = 2'd0;
    localparam logic [1:0] ROW1 = 2'd1;
    localparam logic [1:0] ROW2 = 2'd2;
    localparam logic [1:0] ROW3 = 2'd3;

    // Normalizer widths
    localparam int NV_W       = 52;  // signed vector component into a normalizer
    localparam int MAG_W      = 62;  // magnitude word, leading bit brought to the top
    localparam int M_W        = 30;  // normalized magnitude, largest in [2^29, 2^30)
    localparam int SUM_W      = 64;  // sum of squares, padded to an even width
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 4;
    localparam int SQ_STAGES  = ROOT_W / 2;  // two root bits per stage
    localparam int Q_W        = 18;  // signed unit component, |q| <= 1.0
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_STAGES = DIV_STEPS / 2;
    localparam int NUM_W      = 50;  // dividend and remainder of the divider
    localparam int NORM_LAT   = 6 + SQ_STAGES + 1 + DIV_STAGES + 1;

    // Third axis component width
    localparam int YW = 24;

    // Channel payloads
    typedef struct packed {
        logic signed [D_W-1:0] pos_x;
        logic signed [D_W-1:0] pos_y;
        logic signed [D_W-1:0] pos_z;
        logic signed [D_W-1:0] tgt_x;
        logic signed [D_W-1:0] tgt_y;
        logic signed [D_W-1:0] tgt_z;
        logic signed [D_W-1:0] up_x;
        logic signed [D_W-1:0] up_y;
        logic signed [D_W-1:0] up_z;
    } t_cam_item;

    typedef struct packed {
        logic [1:0]            row_index;
        logic signed [D_W-1:0] col0;
        logic signed [D_W-1:0] col1;
        logic signed [D_W-1:0] col2;
        logic signed [D_W-1:0] col3;
        logic                  last_row;
        logic                  degenerate;
    } t_row_item;

    // Sideband carried through the normalizers
    typedef struct packed {
        logic [2:0][D_W-1:0] p;
        logic [2:0][D_W-1:0] u;
    } t_side1;

    typedef struct packed {
        logic [2:0][D_W-1:0] p;
        logic [2:0][Q_W-1:0] z;
        logic                deg;
    } t_side2;

    // Square root state: partial remainder, root so far, radicand bits left
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  rad;
    } t_sq;

    // Divider state
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } t_dv;

    // One digit of the restoring square root
    function automatic t_sq sq_step(input t_sq s);
        t_sq              o;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {s.rem[REM_W-3:0], s.rad[SUM_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        o.rad = {s.rad[SUM_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of the restoring divider
    function automatic t_dv dv_step(input t_dv s, input logic [ROOT_W-1:0] len,
                                    input int unsigned b);
        t_dv              o;
        logic [NUM_W-1:0] dsh;
        dsh = NUM_W'(len) << b;
        o   = s;
        if (s.rem >= dsh) begin
            o.rem = s.rem - dsh;
            o.q   = s.q | (Q_W'(1) << b);
        end
        return o;
    endfunction

    // Q5.32 to Q8.16, half away from zero, for the third axis
    function automatic logic signed [YW-1:0] rnd_y(input logic signed [36:0] v);
        logic [36:0] mag;
        logic [36:0] r;
        mag = v[36] ? 37'(-v) : 37'(v);
        r   = (mag + 37'd32768) >> 16;
        return v[36] ? -YW'(r) : YW'(r);
    endfunction

    // Round to Q16.16 half away from zero, negate, saturate to 32 bits
    function automatic logic signed [D_W-1:0] rnd_neg_sat(input logic signed [57:0] v);
        logic [57:0] mag;
        logic [57:0] r;
        logic signed [D_W-1:0] res;
        mag = v[57] ? 58'(-v) : 58'(v);
        r   = (mag + 58'd32768) >> 16;
        if (v[57]) begin
            res = (r > 58'h7FFF_FFFF) ? 32'sh7FFF_FFFF : D_W'(r);
        end else begin
            res = (r > 58'h8000_0000) ? 32'sh8000_0000 : -D_W'(r);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/lav_chan_if.sv
// ============================================================================
// lav_chan_if: valid/ready channel
// One transfer per clock edge with valid and ready high; payload type is set
// per instance.
// ============================================================================
`default_nettype none

interface lav_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/lav_norm.sv
// ============================================================================
// lav_norm: pipelined 3-vector normalizer
// Shifts the magnitudes so the largest is in [2^29, 2^30), takes the floor
// square root of the sum of squares and divides each component by it,
// rounded half away from zero. One vector per cycle, stalls on i_en low.
// ============================================================================
`default_nettype none

module lav_norm #(
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [lav_pkg::NV_W-1:0]   i_v [3],
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic signed [lav_pkg::Q_W-1:0]    o_q [3],
    output logic                              o_zero,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int LAT = lav_pkg::NORM_LAT;

    // Control line: valid, sideband, signs, zero flag
    logic              r_vld  [0:LAT-1];
    logic [SIDE_W-1:0] r_side [0:LAT-1];
    logic [2:0]        r_sgn  [0:LAT-1];
    logic              r_zero [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_sgn[0]  <= {i_v[2][lav_pkg::NV_W-1], i_v[1][lav_pkg::NV_W-1],
                          i_v[0][lav_pkg::NV_W-1]};
            r_zero[0] <= (i_v[0] == '0) && (i_v[1] == '0) && (i_v[2] == '0);
            for (int i = 1; i < LAT; i++) begin
                r_side[i] <= r_side[i-1];
                r_sgn[i]  <= r_sgn[i-1];
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    // Stage 1: magnitudes
    logic [lav_pkg::NV_W-1:0]  w_abs [3];
    logic [lav_pkg::MAG_W-1:0] r_sh  [0:3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = i_v[k][lav_pkg::NV_W-1] ? $unsigned(-i_v[k]) : $unsigned(i_v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sh[0][k] <= {{(lav_pkg::MAG_W-lav_pkg::NV_W){1'b0}}, w_abs[k]};
            end
        end
    end

    // Stages 2-4: left shift by 32/16, 8/4, 2/1 until the leading bit is on top
    for (genvar g = 0; g < 3; g++) begin : g_shift
        localparam int SA = 32 >> (2 * g);
        localparam int SB = SA >> 1;
        logic [lav_pkg::MAG_W-1:0] w_a [3];
        logic [lav_pkg::MAG_W-1:0] w_b [3];
        logic [lav_pkg::MAG_W-1:0] w_ora;
        logic [lav_pkg::MAG_W-1:0] w_orb;

        always_comb begin
            w_ora = r_sh[g][0] | r_sh[g][1] | r_sh[g][2];
            for (int k = 0; k < 3; k++) begin
                w_a[k] = (w_ora[lav_pkg::MAG_W-1 -: SA] == '0) ? (r_sh[g][k] << SA)
                                                              : r_sh[g][k];
            end
            w_orb = w_a[0] | w_a[1] | w_a[2];
            for (int k = 0; k < 3; k++) begin
                w_b[k] = (w_orb[lav_pkg::MAG_W-1 -: SB] == '0) ? (w_a[k] << SB) : w_a[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_sh[g+1][k] <= w_b[k];
                end
            end
        end
    end

    // Stage 5: squares; top bits are the normalized magnitude (right shift truncates)
    logic [lav_pkg::M_W-1:0]   r_m5  [3];
    logic [2*lav_pkg::M_W-1:0] r_sq5 [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_m5[k]  <= r_sh[3][k][lav_pkg::MAG_W-1 -: lav_pkg::M_W];
                r_sq5[k] <= r_sh[3][k][lav_pkg::MAG_W-1 -: lav_pkg::M_W]
                          * r_sh[3][k][lav_pkg::MAG_W-1 -: lav_pkg::M_W];
            end
        end
    end

    // Stage 6: sum of squares, square root start
    lav_pkg::t_sq            r_sq [0:lav_pkg::SQ_STAGES];
    logic [lav_pkg::M_W-1:0] r_sm [0:lav_pkg::SQ_STAGES][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0].rem  <= '0;
            r_sq[0].root <= '0;
            r_sq[0].rad  <= lav_pkg::SUM_W'(r_sq5[0]) + lav_pkg::SUM_W'(r_sq5[1])
                          + lav_pkg::SUM_W'(r_sq5[2]);
            r_sm[0]      <= r_m5;
        end
    end

    // Square root: two root bits per stage
    for (genvar s = 0; s < lav_pkg::SQ_STAGES; s++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[s+1] <= lav_pkg::sq_step(lav_pkg::sq_step(r_sq[s]));
                r_sm[s+1] <= r_sm[s];
            end
        end
    end

    // Divider start: dividend is (m << 16) + len/2
    lav_pkg::t_dv               r_dv  [0:lav_pkg::DIV_STAGES][3];
    logic [lav_pkg::ROOT_W-1:0] r_len [0:lav_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= r_sq[lav_pkg::SQ_STAGES].root;
            for (int k = 0; k < 3; k++) begin
                r_dv[0][k].rem <= lav_pkg::NUM_W'({r_sm[lav_pkg::SQ_STAGES][k], 16'h0000})
                                + lav_pkg::NUM_W'(r_sq[lav_pkg::SQ_STAGES].root >> 1);
                r_dv[0][k].q   <= '0;
            end
        end
    end

    // Divider: two quotient bits per stage, three lanes
    for (genvar s = 0; s < lav_pkg::DIV_STAGES; s++) begin : g_div
        localparam int unsigned BH = lav_pkg::DIV_STEPS - 1 - 2 * s;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[s+1] <= r_len[s];
                for (int k = 0; k < 3; k++) begin
                    r_dv[s+1][k] <= lav_pkg::dv_step(
                        lav_pkg::dv_step(r_dv[s][k], r_len[s], BH), r_len[s], BH - 1);
                end
            end
        end
    end

    // Output stage: restore signs
    logic signed [lav_pkg::Q_W-1:0] r_q [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= r_sgn[LAT-2][k] ? -$signed(r_dv[lav_pkg::DIV_STAGES][k].q)
                                          : $signed(r_dv[lav_pkg::DIV_STAGES][k].q);
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_q     = r_q;
    assign o_zero  = r_zero[LAT-1];
    assign o_side  = r_side[LAT-1];

endmodule

`default_nettype wire

>>> design/look_at_view_matrix.sv
// ============================================================================
// look_at_view_matrix: fixed-point look-at view matrix
// Forms z = norm(t - p), x = norm(cross(u, z)), y = cross(z, x) and sends
// the 4x4 view matrix as four row transfers.
// ============================================================================
// Pipeline: the input difference stage, two 33-stage normalizers, two
//   cross-product stages and five dot-product stages feed the row serializer.
// Throughput: one camera setup per four row transfers on the single output
//   channel; the pipeline holds many setups in flight.
// Reset: synchronous, active low; clears all valid bits and the row counter.
// ============================================================================
`default_nettype none

module look_at_view_matrix (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lav_chan_if.sink     i_cam,
    lav_chan_if.source   o_row
);

    localparam int NV = lav_pkg::NV_W;
    localparam int QW = lav_pkg::Q_W;
    localparam int YW = lav_pkg::YW;
    localparam int DW = lav_pkg::D_W;

    logic w_en;
    logic w_ser_free;
    logic r_f_v;

    assign i_cam.ready = w_en;

    // Stage A: forward difference t - p
    logic                r_a_v;
    logic signed [NV-1:0] r_a_d [3];
    lav_pkg::t_side1     r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_cam.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_d[0] <= NV'(i_cam.data.tgt_x) - NV'(i_cam.data.pos_x);
            r_a_d[1] <= NV'(i_cam.data.tgt_y) - NV'(i_cam.data.pos_y);
            r_a_d[2] <= NV'(i_cam.data.tgt_z) - NV'(i_cam.data.pos_z);
            r_a_side.p <= {i_cam.data.pos_z, i_cam.data.pos_y, i_cam.data.pos_x};
            r_a_side.u <= {i_cam.data.up_z, i_cam.data.up_y, i_cam.data.up_x};
        end
    end

    // Forward axis normalizer
    logic                 w_n1_v;
    logic signed [QW-1:0] w_n1_q [3];
    logic                 w_n1_zero;
    lav_pkg::t_side1      w_n1_side;

    lav_norm #(.SIDE_W($bits(lav_pkg::t_side1))) u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_v),
        .i_v     (r_a_d),
        .i_side  (r_a_side),
        .o_valid (w_n1_v),
        .o_q     (w_n1_q),
        .o_zero  (w_n1_zero),
        .o_side  (w_n1_side)
    );

    // Stage B: cross(u, z) products
    logic                 r_b_v;
    logic signed [49:0]   r_b_pr [6];
    lav_pkg::t_side2      r_b_side;
    logic signed [DW-1:0] w_u [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[k] = $signed(w_n1_side.u[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= w_n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_pr[0] <= w_u[1] * w_n1_q[2];
            r_b_pr[1] <= w_u[2] * w_n1_q[1];
            r_b_pr[2] <= w_u[2] * w_n1_q[0];
            r_b_pr[3] <= w_u[0] * w_n1_q[2];
            r_b_pr[4] <= w_u[0] * w_n1_q[1];
            r_b_pr[5] <= w_u[1] * w_n1_q[0];
            r_b_side.p   <= w_n1_side.p;
            r_b_side.z   <= {w_n1_q[2], w_n1_q[1], w_n1_q[0]};
            r_b_side.deg <= w_n1_zero;
        end
    end

    // Stage C: cross(u, z) differences
    logic                 r_c_v;
    logic signed [NV-1:0] r_c_c [3];
    lav_pkg::t_side2      r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_c[0] <= NV'(r_b_pr[0]) - NV'(r_b_pr[1]);
            r_c_c[1] <= NV'(r_b_pr[2]) - NV'(r_b_pr[3]);
            r_c_c[2] <= NV'(r_b_pr[4]) - NV'(r_b_pr[5]);
            r_c_side <= r_b_side;
        end
    end

    // Side axis normalizer
    logic                 w_n2_v;
    logic signed [QW-1:0] w_n2_q [3];
    logic                 w_n2_zero;
    lav_pkg::t_side2      w_n2_side;

    lav_norm #(.SIDE_W($bits(lav_pkg::t_side2))) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_v     (r_c_c),
        .i_side  (r_c_side),
        .o_valid (w_n2_v),
        .o_q     (w_n2_q),
        .o_zero  (w_n2_zero),
        .o_side  (w_n2_side)
    );

    logic signed [QW-1:0] w_z [3];
    logic signed [DW-1:0] w_p [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_z[k] = $signed(w_n2_side.z[k]);
            w_p[k] = $signed(w_n2_side.p[k]);
        end
    end

    // P1: third axis products and translation products for x and z
    logic                 r_p1_v;
    logic signed [35:0]   r_p1_yp [6];
    logic signed [49:0]   r_p1_xp [3];
    logic signed [49:0]   r_p1_zp [3];
    logic signed [QW-1:0] r_p1_x  [3];
    logic signed [QW-1:0] r_p1_z  [3];
    logic signed [DW-1:0] r_p1_p  [3];
    logic                 r_p1_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_n2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_yp[0] <= w_z[1] * w_n2_q[2];
            r_p1_yp[1] <= w_z[2] * w_n2_q[1];
            r_p1_yp[2] <= w_z[2] * w_n2_q[0];
            r_p1_yp[3] <= w_z[0] * w_n2_q[2];
            r_p1_yp[4] <= w_z[0] * w_n2_q[1];
            r_p1_yp[5] <= w_z[1] * w_n2_q[0];
            for (int k = 0; k < 3; k++) begin
                r_p1_xp[k] <= w_n2_q[k] * w_p[k];
                r_p1_zp[k] <= w_z[k] * w_p[k];
            end
            r_p1_x   <= w_n2_q;
            r_p1_z   <= w_z;
            r_p1_p   <= w_p;
            r_p1_deg <= w_n2_side.deg | w_n2_zero;
        end
    end

    // P2: round third axis, sum x.p and z.p
    logic                 r_p2_v;
    logic signed [YW-1:0] r_p2_y  [3];
    logic signed [51:0]   r_p2_xs;
    logic signed [51:0]   r_p2_zs;
    logic signed [QW-1:0] r_p2_x  [3];
    logic signed [QW-1:0] r_p2_z  [3];
    logic signed [DW-1:0] r_p2_p  [3];
    logic                 r_p2_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_y[0] <= lav_pkg::rnd_y(37'(r_p1_yp[0]) - 37'(r_p1_yp[1]));
            r_p2_y[1] <= lav_pkg::rnd_y(37'(r_p1_yp[2]) - 37'(r_p1_yp[3]));
            r_p2_y[2] <= lav_pkg::rnd_y(37'(r_p1_yp[4]) - 37'(r_p1_yp[5]));
            r_p2_xs   <= 52'(r_p1_xp[0]) + 52'(r_p1_xp[1]) + 52'(r_p1_xp[2]);
            r_p2_zs   <= 52'(r_p1_zp[0]) + 52'(r_p1_zp[1]) + 52'(r_p1_zp[2]);
            r_p2_x    <= r_p1_x;
            r_p2_z    <= r_p1_z;
            r_p2_p    <= r_p1_p;
            r_p2_deg  <= r_p1_deg;
        end
    end

    // P3: y.p products, x and z translations
    logic                 r_p3_v;
    logic signed [55:0]   r_p3_yp [3];
    logic signed [DW-1:0] r_p3_tx;
    logic signed [DW-1:0] r_p3_tz;
    logic signed [QW-1:0] r_p3_x  [3];
    logic signed [YW-1:0] r_p3_y  [3];
    logic signed [QW-1:0] r_p3_z  [3];
    logic                 r_p3_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_en) begin
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p3_yp[k] <= r_p2_y[k] * r_p2_p[k];
            end
            r_p3_tx  <= lav_pkg::rnd_neg_sat(58'(r_p2_xs));
            r_p3_tz  <= lav_pkg::rnd_neg_sat(58'(r_p2_zs));
            r_p3_x   <= r_p2_x;
            r_p3_y   <= r_p2_y;
            r_p3_z   <= r_p2_z;
            r_p3_deg <= r_p2_deg;
        end
    end

    // P4: y.p sum
    logic                 r_p4_v;
    logic signed [57:0]   r_p4_ys;
    logic signed [DW-1:0] r_p4_tx;
    logic signed [DW-1:0] r_p4_tz;
    logic signed [QW-1:0] r_p4_x  [3];
    logic signed [YW-1:0] r_p4_y  [3];
    logic signed [QW-1:0] r_p4_z  [3];
    logic                 r_p4_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else if (w_en) begin
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_ys  <= 58'(r_p3_yp[0]) + 58'(r_p3_yp[1]) + 58'(r_p3_yp[2]);
            r_p4_tx  <= r_p3_tx;
            r_p4_tz  <= r_p3_tz;
            r_p4_x   <= r_p3_x;
            r_p4_y   <= r_p3_y;
            r_p4_z   <= r_p3_z;
            r_p4_deg <= r_p3_deg;
        end
    end

    // P5: y translation, final pipeline stage
    logic signed [DW-1:0] r_f_tx;
    logic signed [DW-1:0] r_f_ty;
    logic signed [DW-1:0] r_f_tz;
    logic signed [QW-1:0] r_f_x [3];
    logic signed [YW-1:0] r_f_y [3];
    logic signed [QW-1:0] r_f_z [3];
    logic                 r_f_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_ty  <= lav_pkg::rnd_neg_sat(r_p4_ys);
            r_f_tx  <= r_p4_tx;
            r_f_tz  <= r_p4_tz;
            r_f_x   <= r_p4_x;
            r_f_y   <= r_p4_y;
            r_f_z   <= r_p4_z;
            r_f_deg <= r_p4_deg;
        end
    end

    // Row serializer: holds one matrix, sends rows 0 to 3
    logic                 r_ser_v;
    logic [1:0]           r_row;
    logic signed [DW-1:0] r_s_x [3];
    logic signed [DW-1:0] r_s_y [3];
    logic signed [DW-1:0] r_s_z [3];
    logic signed [DW-1:0] r_s_t [3];
    logic                 r_s_deg;
    logic                 w_load;

    assign w_ser_free = !r_ser_v || (o_row.ready && (r_row == lav_pkg::ROW3));
    assign w_en       = !r_f_v || w_ser_free;
    assign w_load     = r_f_v && w_ser_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v <= 1'b0;
            r_row   <= lav_pkg::ROW0;
        end else if (w_load) begin
            r_ser_v <= 1'b1;
            r_row   <= lav_pkg::ROW0;
        end else if (r_ser_v && o_row.ready) begin
            if (r_row == lav_pkg::ROW3) begin
                r_ser_v <= 1'b0;
            end
            r_row <= r_row + 2'd1;
        end
    end

    // Degenerate matrices are stored as all zeros
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int k = 0; k < 3; k++) begin
                r_s_x[k] <= r_f_deg ? '0 : DW'(r_f_x[k]);
                r_s_y[k] <= r_f_deg ? '0 : DW'(r_f_y[k]);
                r_s_z[k] <= r_f_deg ? '0 : DW'(r_f_z[k]);
            end
            r_s_t[0] <= r_f_deg ? '0 : r_f_tx;
            r_s_t[1] <= r_f_deg ? '0 : r_f_ty;
            r_s_t[2] <= r_f_deg ? '0 : r_f_tz;
            r_s_deg  <= r_f_deg;
        end
    end

    // Row select
    always_comb begin
        o_row.valid           = r_ser_v;
        o_row.data.row_index  = r_row;
        o_row.data.last_row   = (r_row == lav_pkg::ROW3);
        o_row.data.degenerate = r_s_deg;
        case (r_row)
            lav_pkg::ROW0: begin
                o_row.data.col0 = r_s_x[0];
                o_row.data.col1 = r_s_y[0];
                o_row.data.col2 = r_s_z[0];
                o_row.data.col3 = '0;
            end
            lav_pkg::ROW1: begin
                o_row.data.col0 = r_s_x[1];
                o_row.data.col1 = r_s_y[1];
                o_row.data.col2 = r_s_z[1];
                o_row.data.col3 = '0;
            end
            lav_pkg::ROW2: begin
                o_row.data.col0 = r_s_x[2];
                o_row.data.col1 = r_s_y[2];
                o_row.data.col2 = r_s_z[2];
                o_row.data.col3 = '0;
            end
            lav_pkg::ROW3: begin
                o_row.data.col0 = r_s_t[0];
                o_row.data.col1 = r_s_t[1];
                o_row.data.col2 = r_s_t[2];
                o_row.data.col3 = r_s_deg ? '0 : lav_pkg::Q_ONE;
            end
            default: begin
                o_row.data.col0 = '0;
                o_row.data.col1 = '0;
                o_row.data.col2 = '0;
                o_row.data.col3 = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A degenerate matrix carries only zero elements
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && o_row.data.degenerate) |->
        (o_row.data.col0 == '0 && o_row.data.col1 == '0 &&
         o_row.data.col2 == '0 && o_row.data.col3 == '0))
        else $error("degenerate row with nonzero element");

    // After a non-last row transfer the next row of the same matrix follows
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && o_row.ready && !o_row.data.last_row) |=>
        (o_row.valid && o_row.data.row_index == $past(o_row.data.row_index) + 2'd1))
        else $error("row sequence broken");

    // A finished matrix waiting on a busy serializer is held, not dropped
    a_hold_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_v && !w_ser_free) |=> r_f_v)
        else $error("final stage lost a matrix");

    // A new matrix only loads after row 3 has gone out
    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_ser_v) |-> (o_row.ready && r_row == lav_pkg::ROW3))
        else $error("serializer overwritten mid-matrix");
`endif

endmodule

`default_nettype wire
